>>> rtl/linear_probe_hash_table_unit_defines.svh
// assertion helpers for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define LPHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
package lpht_pkg;

    // request and result field widths
    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int SLOT_W    = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // status of the home slot reduction unit
    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

>>> rtl/lpht_mod.sv
module lpht_mod #(
    parameter int NUM_SLOTS = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lpht_pkg::KEY_W-1:0]   dividend,
    output lpht_pkg::mod_stat_t          stat,
    output logic [$clog2(NUM_SLOTS)-1:0] rem
);
    import lpht_pkg::*;

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int PROD_W = 2 * KEY_W + 1;

    // reciprocal rounded up, exact quotient for every key of KEY_W bits
    localparam int          RECIP_SHIFT = KEY_W + IDX_W;
    localparam logic [63:0] RECIP_WIDE  =
        ((64'd1 << RECIP_SHIFT) + 64'(NUM_SLOTS) - 64'd1) / 64'(NUM_SLOTS);
    localparam logic [KEY_W:0] RECIP    = RECIP_WIDE[KEY_W:0];

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 phase_reg, phase_next;
    logic [KEY_W-1:0]     dvd_reg, dvd_next;
    logic [KEY_W-1:0]     quot_reg, quot_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    prod;
    logic [KEY_W-1:0]     back;

    // quotient by reciprocal multiply, then remainder from the quotient
    assign prod = PROD_W'(dvd_reg) * PROD_W'(RECIP);
    assign back = quot_reg * KEY_W'(NUM_SLOTS);

    // two step sequencer: quotient, then remainder
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            dvd_next   = dividend;
        end
        else if (busy_reg && !phase_reg)
        begin
            quot_next  = KEY_W'(prod >> RECIP_SHIFT);
            phase_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = IDX_W'(dvd_reg - back);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

>>> rtl/linear_probe_hash_table_unit.sv
// Open-addressed hash table of NUM_SLOTS slots with linear probing.
// Requests come in on the s_axis channel: operation in tuser (insert,
// search, delete), key in tdata. Each request gives exactly one result on
// m_axis: status in tuser (0 done or found, 1 table full or key absent),
// slot index of a key found by a search in tdata (zero for every other outcome).
// A request first reduces the key to its home slot by reciprocal
// multiplication (quotient, then remainder), reads the home slot, then
// compares one slot a cycle through the slot memory (one read port, one
// write port), stopping at the first match or after a full lap.
// A request makes from 0 to NUM_SLOTS-1 probes past the home slot; one
// request is in work at a time, so a new request is taken only after the
// last one has put its result in the output register. The unused operation
// code runs a full lap and reports failure without touching the table.
// After reset the block sweeps the slot memory, one slot a cycle,
// and holds s_axis_tready low meanwhile.
// The result sits in an output register: a new request is accepted while
// it waits, and a finished lookup holds until m_axis_tready frees it.
`include "linear_probe_hash_table_unit_defines.svh"

module linear_probe_hash_table_unit #(
    parameter int NUM_SLOTS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[30:0], zero pad [31]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // slot[4:0], zero pad [7:5]
    output logic [0:0]  m_axis_tuser    // status[0]
);
    import lpht_pkg::*;

    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int STATE_W = 2;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

    localparam logic [STATE_W-1:0] ST_CLEAR = 2'd0;
    localparam logic [STATE_W-1:0] ST_IDLE  = 2'd1;
    localparam logic [STATE_W-1:0] ST_MOD   = 2'd2;
    localparam logic [STATE_W-1:0] ST_PROBE = 2'd3;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;

    logic [KEY_W:0]     mem [NUM_SLOTS];
    logic [KEY_W:0]     rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [KEY_W:0]     wr_data;

    mod_stat_t          mod_stat;
    logic [IDX_W-1:0]   mod_rem;

    logic               accept;
    logic [IDX_W-1:0]   ptr_inc;
    logic               last_probe;
    logic               slot_used;
    logic               hit;
    logic               probe_end;
    logic               out_free;
    logic               finish;

    // home slot reduction
    lpht_mod #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (s_axis_tdata[KEY_W-1:0]),
        .stat     (mod_stat),
        .rem      (mod_rem)
    );

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // probe pointer wraps from the last slot to slot zero
    assign ptr_inc    = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign last_probe = (cnt_reg == LAST_SLOT);
    assign slot_used  = rd_data_reg[KEY_W];

    // slot match for the operation in work
    always_comb
    begin
        unique case (op_reg)
            OP_INSERT: hit = !slot_used;
            OP_SEARCH,
            OP_DELETE: hit = slot_used && (rd_data_reg[KEY_W-1:0] == key_reg);
            default:   hit = 1'b0;
        endcase
    end

    assign probe_end = (state_reg == ST_PROBE) && (hit || last_probe);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign finish    = probe_end && out_free;

    // read address runs one slot ahead of the compare
    always_comb
    begin
        priority if (state_reg == ST_MOD)
            rd_addr = mod_rem;
        else if ((state_reg == ST_PROBE) && !probe_end)
            rd_addr = ptr_inc;
        else
            rd_addr = ptr_reg;
    end

    // slot memory write: clearing sweep, insert, delete
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (finish && hit && (op_reg == OP_INSERT))
        begin
            wr_en   = 1'b1;
            wr_data = {1'b1, key_reg};
        end
        else if (finish && hit && (op_reg == OP_DELETE))
        begin
            wr_en   = 1'b1;
            wr_data = {1'b0, rd_data_reg[KEY_W-1:0]};
        end
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ptr_next = ptr_inc;
                if (ptr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_axis_tuser;
                    key_next   = s_axis_tdata[KEY_W-1:0];
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    ptr_next   = mod_rem;
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!probe_end)
                begin
                    ptr_next = ptr_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = hit ? STATUS_OK : STATUS_FAIL;
                    out_slot_next   = (hit && (op_reg == OP_SEARCH)) ?
                                      SLOT_W'(ptr_reg) : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {3'b000, out_slot_reg};
    assign m_axis_tuser[0] = out_status_reg;

    // checks
    `LPHT_ASSERT_IMP(a_ready_idle, s_axis_tready, !mod_stat.busy && !mod_stat.done, "unit busy")
    `LPHT_ASSERT_NXT(a_accept_to_mod, accept, state_reg == ST_MOD, "reduction not started")
    `LPHT_ASSERT_IMP(a_done_in_mod, mod_stat.done, state_reg == ST_MOD, "done outside reduction")
    `LPHT_ASSERT_IMP(a_ptr_range, state_reg == ST_PROBE, ptr_reg <= LAST_SLOT, "pointer too far")
    `LPHT_ASSERT_IMP(a_res_src, $rose(m_axis_tvalid), $past(state_reg) == ST_PROBE, "stray result")

endmodule
